### src/sem_pkg.sv
// Shared types, constants and helper functions for the Sobel edge magnitude block.
// Used by sobel_edge_magnitude_rgb, sem_isqrt and the testbench; depends on nothing.
package sem_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 3;
    localparam int GRAD_W  = 11;
    localparam int NORM_W  = 21;
    localparam int CFG_W   = 11;

    // Squared magnitude above which the rounded root would exceed 255.
    localparam logic [NORM_W-1:0] SAT_LIMIT = NORM_W'(255 * 255 + 255);
    localparam logic [CHAN_W-1:0] SAT_VALUE = 8'd255;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]         pixel_t;
    typedef logic [8:0][PIX_W-1:0]    window_t;
    typedef logic [8:0][CHAN_W-1:0]   chan_win_t;
    typedef logic signed [GRAD_W-1:0] grad_t;
    typedef logic [CHAN_W-1:0]        chan_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_UPD  = 6'b000100,
        ST_GRAD = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    function automatic grad_t sobel_gx(input chan_win_t w);
        logic signed [GRAD_W:0] acc;
        acc = $signed({4'b0, w[2]}) + ($signed({4'b0, w[5]}) <<< 1) + $signed({4'b0, w[8]})
            - $signed({4'b0, w[0]}) - ($signed({4'b0, w[3]}) <<< 1) - $signed({4'b0, w[6]});
        return grad_t'(acc);
    endfunction

    function automatic grad_t sobel_gy(input chan_win_t w);
        logic signed [GRAD_W:0] acc;
        acc = $signed({4'b0, w[6]}) + ($signed({4'b0, w[7]}) <<< 1) + $signed({4'b0, w[8]})
            - $signed({4'b0, w[0]}) - ($signed({4'b0, w[1]}) <<< 1) - $signed({4'b0, w[2]});
        return grad_t'(acc);
    endfunction

endpackage

### src/sem_isqrt.sv
// Rounded integer square root of Gx^2 + Gy^2 for three channels, saturated at 255.
// One result bit per cycle, then a rounding step. Depends on sem_pkg.
module sem_isqrt
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sem_pkg::grad_t       gx [sem_pkg::NCHAN],
    input  sem_pkg::grad_t       gy [sem_pkg::NCHAN],
    output logic                 done,
    output sem_pkg::chan_t       root [sem_pkg::NCHAN]
);

    logic                              busy_reg, busy_next;
    logic                              rnd_reg, rnd_next;
    logic                              done_reg, done_next;
    logic [2:0]                        step_reg;
    logic [sem_pkg::NORM_W-1:0]        n_reg [sem_pkg::NCHAN];
    sem_pkg::chan_t                    s_reg [sem_pkg::NCHAN];
    sem_pkg::chan_t                    s_next [sem_pkg::NCHAN];
    sem_pkg::chan_t                    root_reg [sem_pkg::NCHAN];
    sem_pkg::chan_t                    root_next [sem_pkg::NCHAN];
    logic [sem_pkg::NORM_W-1:0]        n_next [sem_pkg::NCHAN];

    always_comb
    begin
        busy_next = busy_reg;
        rnd_next  = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && step_reg == 3'd0)
        begin
            busy_next = 1'b0;
            rnd_next  = 1'b1;
        end
        if (rnd_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_comb
    begin
        logic [sem_pkg::CHAN_W-1:0]          t;
        logic [2*sem_pkg::CHAN_W-1:0]        tt;
        logic [2*sem_pkg::CHAN_W-1:0]        sq;
        logic [2*sem_pkg::CHAN_W:0]          ss;
        logic signed [sem_pkg::NORM_W-1:0]   gxe;
        logic signed [sem_pkg::NORM_W-1:0]   gye;
        for (int c = 0; c < sem_pkg::NCHAN; c++)
        begin
            gxe = sem_pkg::NORM_W'(gx[c]);
            gye = sem_pkg::NORM_W'(gy[c]);
            n_next[c] = sem_pkg::NORM_W'(gxe * gxe + gye * gye);
            t  = s_reg[c] | (sem_pkg::CHAN_W'(1) << step_reg);
            tt = t * t;
            s_next[c] = s_reg[c];
            if ({5'b0, tt} <= n_reg[c])
            begin
                s_next[c] = t;
            end
            sq = s_reg[c] * s_reg[c];
            ss = {1'b0, sq} + {9'b0, s_reg[c]};
            if (n_reg[c] > sem_pkg::SAT_LIMIT)
            begin
                root_next[c] = sem_pkg::SAT_VALUE;
            end
            else if (n_reg[c] > {4'b0, ss})
            begin
                root_next[c] = s_reg[c] + 8'd1;
            end
            else
            begin
                root_next[c] = s_reg[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
            if (start)
            begin
                step_reg <= 3'd7;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < sem_pkg::NCHAN; c++)
        begin
            if (start)
            begin
                n_reg[c] <= n_next[c];
                s_reg[c] <= '0;
            end
            else if (busy_reg)
            begin
                s_reg[c] <= s_next[c];
            end
            if (rnd_reg)
            begin
                root_reg[c] <= root_next[c];
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### src/sobel_edge_magnitude_rgb.sv
// Top level of the RGB Sobel edge magnitude block: line store, window and control.
// Depends on sem_pkg and sem_isqrt.
//
// Usage. Pixels enter in raster order on the s_axis channel; tuser = 0 marks a
// pixel, tuser = 1 a drain transaction that releases one pending result after the
// whole frame is in. Results leave on m_axis, one per pixel once the stream is
// width+1 pixels ahead; tlast marks the last result of the frame. Frame width and
// height are set on the APB port (offsets 0 and 4); a write restarts the frame and
// must only be made while the block is idle.
// Each transaction is processed on its own: a pixel that gives no result passes the
// line store read and window update; one that does also passes the gradient
// register, 8 root iterations, rounding and output load. A drain walks up to three
// positions, each a line store read and write back. The bit-serial square root
// is the bulk of the work for each result.
// The output register holds a result while the receiver stalls, and a new input
// transaction is accepted meanwhile; the block waits only when a second result is
// ready and the first is still held. Reset clears the counters and the window and
// sets both dimensions to 1024; the line store is not cleared, since a column is
// only read in rows after this frame wrote it.
module sobel_edge_magnitude_rgb
#(
    parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_red [7:0], in_green [15:8], in_blue [23:16]
    input  logic        s_axis_tuser,   // cmd [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int EXT_W  = (WDIM_W > sem_pkg::CFG_W ? WDIM_W : sem_pkg::CFG_W)
                          + (HDIM_W > sem_pkg::CFG_W ? HDIM_W : sem_pkg::CFG_W);
    localparam int TOT_W  = WDIM_W + HDIM_W;
    localparam int K_W    = TOT_W + 1;

    sem_pkg::state_t               state_reg, state_next;
    logic [sem_pkg::CFG_W-1:0]     width_reg, height_reg;
    logic [WDIM_W-1:0]             wd_eff;
    logic [HDIM_W-1:0]             ht_eff;
    logic [TOT_W-1:0]              total;
    logic [COL_W-1:0]              col_reg;
    logic [1:0]                    row_reg;
    logic [K_W-1:0]                kcnt_reg;
    logic [TOT_W-1:0]              pin_reg, pout_reg;
    logic [1:0]                    tries_reg;
    logic                          drain_reg;
    logic                          end_reg;
    sem_pkg::pixel_t               px_reg;
    sem_pkg::window_t              win_reg, win_new, src_win;
    logic [2*sem_pkg::PIX_W-1:0]   mem [MAX_WIDTH];
    logic [2*sem_pkg::PIX_W-1:0]   rd_reg;
    sem_pkg::pixel_t               top_px, mid_px;
    logic                          made;
    logic                          col_wrap;
    logic                          last_out;
    logic                          cfg_wr;
    logic                          in_acc;
    logic                          load_out;
    sem_pkg::grad_t                gx_reg [sem_pkg::NCHAN];
    sem_pkg::grad_t                gy_reg [sem_pkg::NCHAN];
    sem_pkg::chan_t                root [sem_pkg::NCHAN];
    logic                          root_done;
    logic                          m_valid_reg;
    logic [23:0]                   m_data_reg;
    logic                          m_last_reg;

    // Effective dimensions: zero acts as one, oversize values clamp to the maximum.
    always_comb
    begin
        logic [EXT_W-1:0] w_ext, h_ext;
        w_ext = EXT_W'(width_reg);
        h_ext = EXT_W'(height_reg);
        if (width_reg == '0)
        begin
            wd_eff = WDIM_W'(1);
        end
        else if (w_ext > EXT_W'(MAX_WIDTH))
        begin
            wd_eff = WDIM_W'(MAX_WIDTH);
        end
        else
        begin
            wd_eff = WDIM_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            ht_eff = HDIM_W'(1);
        end
        else if (h_ext > EXT_W'(MAX_HEIGHT))
        begin
            ht_eff = HDIM_W'(MAX_HEIGHT);
        end
        else
        begin
            ht_eff = HDIM_W'(height_reg);
        end
    end

    assign total  = TOT_W'(wd_eff) * TOT_W'(ht_eff);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == sem_pkg::REG_HEIGHT) ? {21'b0, height_reg} : {21'b0, width_reg};

    assign s_axis_tready = (state_reg == sem_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Neighbourhood formation for the position at col_reg.
    always_comb
    begin
        top_px = (row_reg >= 2'd2) ? rd_reg[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W] : '0;
        mid_px = (row_reg >= 2'd1) ? rd_reg[sem_pkg::PIX_W-1:0] : '0;
        made   = kcnt_reg >= (K_W'(wd_eff) + K_W'(1));
        col_wrap = (WDIM_W'(col_reg) + WDIM_W'(1)) >= wd_eff;
        win_new = '0;
        src_win = '0;
        for (int r = 0; r < 3; r++)
        begin
            if (col_reg == '0)
            begin
                src_win[r*3]     = win_reg[r*3+1];
                src_win[r*3 + 1] = win_reg[r*3+2];
            end
            else
            begin
                win_new[r*3]     = win_reg[r*3+1];
                win_new[r*3 + 1] = win_reg[r*3+2];
            end
        end
        win_new[2] = top_px;
        win_new[5] = mid_px;
        win_new[8] = px_reg;
        if (col_reg != '0)
        begin
            src_win = win_new;
        end
        last_out = drain_reg && ((pout_reg + TOT_W'(1)) >= total);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sem_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser == sem_pkg::CMD_PIXEL)
                    begin
                        if (pin_reg < total)
                        begin
                            state_next = sem_pkg::ST_READ;
                        end
                    end
                    else if (pin_reg >= total && pout_reg < total)
                    begin
                        state_next = sem_pkg::ST_READ;
                    end
                end
            end
            sem_pkg::ST_READ:
            begin
                state_next = sem_pkg::ST_UPD;
            end
            sem_pkg::ST_UPD:
            begin
                if (made)
                begin
                    state_next = sem_pkg::ST_GRAD;
                end
                else if (drain_reg && tries_reg != 2'd2)
                begin
                    state_next = sem_pkg::ST_READ;
                end
                else
                begin
                    state_next = sem_pkg::ST_IDLE;
                end
            end
            sem_pkg::ST_GRAD:
            begin
                state_next = sem_pkg::ST_ROOT;
            end
            sem_pkg::ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = sem_pkg::ST_DONE;
                end
            end
            sem_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = sem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase
    end

    assign load_out = (state_reg == sem_pkg::ST_DONE) && (!m_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sem_pkg::ST_IDLE;
            width_reg   <= sem_pkg::CFG_W'(1024);
            height_reg  <= sem_pkg::CFG_W'(1024);
            col_reg     <= '0;
            row_reg     <= '0;
            kcnt_reg    <= '0;
            pin_reg     <= '0;
            pout_reg    <= '0;
            tries_reg   <= '0;
            drain_reg   <= 1'b0;
            end_reg     <= 1'b0;
            win_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                if (paddr[2] == sem_pkg::REG_HEIGHT)
                begin
                    height_reg <= pwdata[sem_pkg::CFG_W-1:0];
                end
                else
                begin
                    width_reg <= pwdata[sem_pkg::CFG_W-1:0];
                end
                col_reg  <= '0;
                row_reg  <= '0;
                kcnt_reg <= '0;
                pin_reg  <= '0;
                pout_reg <= '0;
                win_reg  <= '0;
            end
            else if (state_reg == sem_pkg::ST_IDLE && state_next == sem_pkg::ST_READ)
            begin
                drain_reg <= s_axis_tuser;
                tries_reg <= '0;
                if (s_axis_tuser == sem_pkg::CMD_PIXEL)
                begin
                    pin_reg <= pin_reg + TOT_W'(1);
                end
            end
            else if (state_reg == sem_pkg::ST_UPD)
            begin
                tries_reg <= tries_reg + 2'd1;
                end_reg   <= made && last_out;
                if (made && last_out)
                begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    kcnt_reg <= '0;
                    pin_reg  <= '0;
                    pout_reg <= '0;
                    win_reg  <= '0;
                end
                else
                begin
                    win_reg  <= win_new;
                    kcnt_reg <= kcnt_reg + K_W'(1);
                    if (made)
                    begin
                        pout_reg <= pout_reg + TOT_W'(1);
                    end
                    if (col_wrap)
                    begin
                        col_reg <= '0;
                        if (row_reg != 2'd2)
                        begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    // Line store: read in the read state, written back in the update state.
    always_ff @(posedge clk)
    begin
        if (state_reg == sem_pkg::ST_READ)
        begin
            rd_reg <= mem[col_reg];
        end
        if (state_reg == sem_pkg::ST_UPD)
        begin
            mem[col_reg] <= {rd_reg[sem_pkg::PIX_W-1:0], px_reg};
        end
    end

    // Channel c: 0 is red (bits 23..16), 1 green, 2 blue.
    function automatic sem_pkg::chan_win_t chan_of(input sem_pkg::window_t w, input int c);
        sem_pkg::chan_win_t r;
        for (int i = 0; i < 9; i++)
        begin
            r[i] = w[i][(2 - c) * sem_pkg::CHAN_W +: sem_pkg::CHAN_W];
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        chan_win_t_gen : for (int c = 0; c < sem_pkg::NCHAN; c++)
        begin
            if (state_reg == sem_pkg::ST_UPD)
            begin
                gx_reg[c] <= sem_pkg::sobel_gx(chan_of(src_win, c));
                gy_reg[c] <= sem_pkg::sobel_gy(chan_of(src_win, c));
            end
        end
        if (state_reg == sem_pkg::ST_IDLE)
        begin
            // Drain transactions push a zero pixel below the frame.
            if (s_axis_tuser == sem_pkg::CMD_PIXEL)
            begin
                px_reg <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
            end
            else
            begin
                px_reg <= '0;
            end
        end
        if (load_out)
        begin
            m_data_reg <= {root[2], root[1], root[0]};
            m_last_reg <= end_reg;
        end
    end

    sem_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == sem_pkg::ST_GRAD),
        .gx    (gx_reg),
        .gy    (gy_reg),
        .done  (root_done),
        .root  (root)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

### src/sem_checker.sv
// Port-level checks for sobel_edge_magnitude_rgb, attached by the bind below.
// Depends only on the top level's ports.
module sem_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while the receiver stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while the receiver stalled");

    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without the block having been busy");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### test/sobel_edge_magnitude_rgb_tb.sv
// Self-checking testbench for sobel_edge_magnitude_rgb: random RGB frames with a local predictor.
// Depends on sem_pkg and the block's RTL; drives the stream and APB ports, checks every result.
`timescale 1ns / 100ps

module sobel_edge_magnitude_rgb_tb;

    localparam int LINE_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1500;

    typedef logic [23:0] nbhd_t [9];
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sobel_edge_magnitude_rgb u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state: a private copy of the block's registers, line store and window.
    logic [10:0]  width_reg;
    logic [10:0]  height_reg;
    logic [47:0]  line_copy [LINE_DEPTH];
    nbhd_t        win_copy;
    int           col_pos;
    int           row_pos;
    int           pix_in;
    int           res_out;

    edge_result_t expected_edges [$];
    int           mismatch_count;
    int           cycle_count;
    int           item_count;
    bit           idle_enable;
    bit           hold_on;
    event         hold_go;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int clamp_dim(input logic [10:0] v);
        if (v == 0)
            return 1;
        if (v > LINE_DEPTH)
            return LINE_DEPTH;
        return int'(v);
    endfunction

    function automatic logic [7:0] grad_mag(input nbhd_t w, input int sh);
        int c [9];
        int gx;
        int gy;
        int n;
        int s;
        int t;
        int b;
        for (int i = 0; i < 9; i++)
            c[i] = (w[i] >> sh) & 255;
        gx = c[2] + 2 * c[5] + c[8] - c[0] - 2 * c[3] - c[6];
        gy = c[6] + 2 * c[7] + c[8] - c[0] - 2 * c[1] - c[2];
        n = gx * gx + gy * gy;
        if (n > 255 * 255 + 255)
            return 8'd255;
        s = 0;
        for (b = 128; b > 0; b = b >> 1)
        begin
            t = s | b;
            if (t * t <= n)
                s = t;
        end
        if (n > s * s + s)
            s++;
        return s[7:0];
    endfunction

    function automatic edge_result_t make_edge(input nbhd_t w);
        edge_result_t e;
        e.red   = grad_mag(w, 16);
        e.green = grad_mag(w, 8);
        e.blue  = grad_mag(w, 0);
        e.last  = 1'b0;
        return e;
    endfunction

    task automatic restart_copy();
        for (int i = 0; i < 9; i++)
            win_copy[i] = '0;
        col_pos = 0;
        row_pos = 0;
        pix_in  = 0;
        res_out = 0;
    endtask

    // Moves the window one raster position on; px is a real pixel or a zero below the frame.
    task automatic advance_window(input logic [23:0] px, output bit made, output edge_result_t e);
        int          wd;
        int          k;
        logic [47:0] entry;
        nbhd_t       shifted;
        wd    = clamp_dim(width_reg);
        k     = row_pos * wd + col_pos;
        entry = line_copy[col_pos];
        made  = 1'b0;
        e     = '{default: '0};
        if (col_pos == 0)
        begin
            if (k >= wd + 1)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    shifted[r * 3]     = win_copy[r * 3 + 1];
                    shifted[r * 3 + 1] = win_copy[r * 3 + 2];
                    shifted[r * 3 + 2] = '0;
                end
                e    = make_edge(shifted);
                made = 1'b1;
            end
            for (int i = 0; i < 9; i++)
                win_copy[i] = '0;
        end
        else
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_copy[r * 3]     = win_copy[r * 3 + 1];
                win_copy[r * 3 + 1] = win_copy[r * 3 + 2];
            end
        end
        win_copy[2] = (row_pos >= 2) ? entry[47:24] : 24'd0;
        win_copy[5] = (row_pos >= 1) ? entry[23:0] : 24'd0;
        win_copy[8] = px;
        if (col_pos != 0 && k >= wd + 1)
        begin
            e    = make_edge(win_copy);
            made = 1'b1;
        end
        line_copy[col_pos] = {entry[23:0], px};
        if (col_pos + 1 >= wd)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
            col_pos++;
    endtask

    task automatic predict_edge(input logic cmd, input logic [23:0] px);
        int           total;
        bit           made;
        edge_result_t e;
        total = clamp_dim(width_reg) * clamp_dim(height_reg);
        if (cmd == sem_pkg::CMD_PIXEL)
        begin
            if (pix_in >= total)
                return;
            pix_in++;
            advance_window(px, made, e);
            if (made)
            begin
                res_out++;
                expected_edges.push_back(e);
            end
            return;
        end
        if (pix_in < total || res_out >= total)
            return;
        made = 1'b0;
        for (int tries = 0; tries < 3 && !made; tries++)
            advance_window(24'd0, made, e);
        if (!made)
            return;
        res_out++;
        if (res_out >= total)
        begin
            e.last = 1'b1;
            restart_copy();
        end
        expected_edges.push_back(e);
    endtask

    // One stream transaction; tvalid is only lowered while idling, so back-to-back items
    // never see two assignments to it in one step.
    task automatic send_item(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        while (idle_enable && $urandom_range(0, 99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {b, g, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_edge(cmd, {r, g, b});
        item_count++;
    endtask

    task automatic send_pixel_random();
        send_item(sem_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_drain();
        send_item(sem_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Waits until every expected result is back and the block has finished any silent work.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [10:0] value);
        logic [31:0] word;
        word = {21'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == sem_pkg::REG_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        restart_copy();
    endtask

    task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
        wait_quiet();
        apb_write(sem_pkg::REG_WIDTH, w);
        apb_write(sem_pkg::REG_HEIGHT, h);
    endtask

    task automatic flush_frame();
        while (pix_in >= clamp_dim(width_reg) * clamp_dim(height_reg)
               && res_out < clamp_dim(width_reg) * clamp_dim(height_reg))
            send_drain();
    endtask

    task automatic test_directed();
        set_frame(11'd3, 11'd2);
        send_drain();  // early drain, ignored
        send_item(sem_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd255);
        send_item(sem_pkg::CMD_PIXEL, 8'd0, 8'd255, 8'd0);
        send_item(sem_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        send_item(sem_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        send_item(sem_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd0);
        send_item(sem_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd255);
        send_item(sem_pkg::CMD_PIXEL, 8'd128, 8'd127, 8'd1);  // beyond the frame, ignored
        flush_frame();
        send_drain();  // a new frame has begun, so this one is ignored too
        // Out-of-range registers: zero acts as one, giving a single-pixel frame.
        set_frame(11'd0, 11'd0);
        send_item(sem_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        flush_frame();
        // A write part way through a frame restarts it.
        set_frame(11'd4, 11'd4);
        repeat (6) send_pixel_random();
        set_frame(11'd2, 11'd3);
        repeat (6) send_pixel_random();
        flush_frame();
    endtask

    task automatic test_extremes();
        // An oversize width clamps to the line store depth; the second row's first
        // results show where the rows wrapped. The frame is left open and restarted.
        set_frame(11'd2047, 11'd2);
        repeat (1030) send_pixel_random();
        set_frame(11'd1, 11'd2047);
        repeat (5) send_pixel_random();
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills and stalls.
    task automatic test_backpressure();
        set_frame(11'd5, 11'd6);
        -> hold_go;
        repeat (30) send_pixel_random();
        flush_frame();
        wait_quiet();
    endtask

    task automatic run_random_frame(input bit noisy);
        int w;
        int h;
        int total;
        int cut;
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        set_frame(11'(w), 11'(h));
        total = clamp_dim(11'(w)) * clamp_dim(11'(h));
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total) : total;
        for (int i = 0; i < cut; i++)
        begin
            if (noisy && $urandom_range(0, 99) < 8)
                send_drain();
            send_pixel_random();
        end
        if (cut < total)
            return;
        if (noisy && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_pixel_random();
        flush_frame();
    endtask

    task automatic test_random_frames();
        idle_enable = 1'b0;
        repeat (6) run_random_frame(1'b1);
        idle_enable = 1'b1;
        while (item_count < ITEM_TARGET)
            run_random_frame($urandom_range(0, 3) != 0);
    endtask

    // Long receiver stall, started by the back-pressure test.
    always
    begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_edges.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: tdata=%h tlast=%b", m_axis_tdata,
                                 m_axis_tlast);
                end
                else
                begin
                    edge_result_t e;
                    e = expected_edges.pop_front();
                    if (m_axis_tdata !== {e.blue, e.green, e.red} || m_axis_tlast !== e.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display(
                                "mismatch: exp rgb %0d %0d %0d last %b, got %0d %0d %0d last %b",
                                e.red, e.green, e.blue, e.last, m_axis_tdata[7:0],
                                m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tlast);
                    end
                end
            end
            if (hold_on)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= !(idle_enable && $urandom_range(0, 99) < 27);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sobel_edge_magnitude_rgb test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        item_count     = 0;
        idle_enable    = 1'b1;
        width_reg      = 11'd1024;
        height_reg     = 11'd1024;
        for (int i = 0; i < LINE_DEPTH; i++)
            line_copy[i] = '0;
        restart_copy();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extremes();
        test_backpressure();
        test_random_frames();

        s_axis_tvalid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_edges.size() == 0)
            $display("sobel_edge_magnitude_rgb test passed");
        else
            $display("sobel_edge_magnitude_rgb test failed");
        $finish;
    end

endmodule
